### rtl/fbir_pkg.sv
// Package for the frame bit interleave remapper: request and result payloads,
// action codes, the sequence-counter status struct and the bit-spreading helper.
// No dependencies.
`default_nettype none

package fbir_pkg;

   // Action codes of a request.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Fixed field limits: rows stay below 64, at most four 64-pixel groups per row.
   localparam int ROW_W        = 6;
   localparam int GROUP_W      = 2;
   localparam int PASS_W       = 3;
   localparam int GROUP_PIXELS = 64;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] src_byte;
      logic [9:0] read_addr;
   } req_type;

   typedef struct packed {
      logic [7:0] dst_byte;
      logic       frame_complete;
   } rsp_type;

   // Status of the sequence counter for the next push.
   typedef struct packed {
      logic               in_frame;
      logic               row_ok;
      logic               complete;
      logic [ROW_W-1:0]   row;
      logic [GROUP_W-1:0] group;
      logic [PASS_W-1:0]  pass;
   } seq_info_type;

   // Places source bit b at bit 8*b of a 64-bit word.
   function automatic logic [63:0] spread_bits(input logic [7:0] value);
      logic [63:0] result;
      result = '0;
      for (int b = 0; b < 8; b++) begin
         result[8*b] = value[b];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/frame_bit_interleave_remap_top.sv
// Top level of the frame bit interleave remapper: request decode, push
// read-modify-write sequencer, per-word valid bits and the result register.
// Depends on fbir_pkg, fbir_ram and fbir_seq.
`default_nettype none

// The block turns a monochrome frame pushed in an interleaved source order into a
// row-major, MSB-first bitmap of WIDTH x HEIGHT pixels kept in a 64-bit-wide frame
// RAM. A start request clears the frame and the push counter; the RAM is not
// swept, since a valid bit per word marks what has been written and an unwritten
// word reads as zero. A push request sets up to eight pixels of one row with a
// read-modify-write of the frame RAM: it occupies the block through address
// multiply, mask build, RAM read and write back, plus a second write back when
// WIDTH is not a multiple of 64 and the 64-pixel group straddles two RAM words.
// Pushes past a full frame, and pushes that land below the last row, change no
// pixel. A read request returns one result from the registered read of the frame
// RAM through the result register; it waits in the read state while the result
// register is still held by a stall. Start and unused action codes give no
// result. The block takes one request at a time, but a new request is accepted
// while an earlier result is still waiting in the output register.
module frame_bit_interleave_remap_top #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire fbir_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fbir_pkg::rsp_type      rsp_payload
);
   import fbir_pkg::*;

   // Frame geometry. Every RAM word holds 64 consecutive row-major pixels.
   localparam int FRAME_BYTES = (WIDTH * HEIGHT) / 8;
   localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
   localparam int AW          = $clog2(FRAME_WORDS);
   localparam int PW          = $clog2(WIDTH * HEIGHT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_MASK,
      ST_WR0,
      ST_WR1,
      ST_READ
   } state_type;

   state_type            state_ff, state_in;
   logic [FRAME_WORDS-1:0] valid_ff, valid_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [GROUP_W-1:0]   group_ff, group_in;
   logic [PASS_W-1:0]    pass_ff, pass_in;
   logic [7:0]           src_ff, src_in;
   logic [PW-1:0]        base_ff, base_in;
   logic [63:0]          hi_ff, hi_in;
   logic [63:0]          lo_ff, lo_in;
   logic [2:0]           sel_ff, sel_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 cmp_ff, cmp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 seq_clear;
   logic                 seq_push;
   seq_info_type         seq_info;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [63:0]          ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [63:0]          ram_rd_data;

   logic [AW-1:0]        word0;
   logic [AW-1:0]        word1;
   logic [AW-1:0]        read_word;
   logic                 read_in_range;
   logic [127:0]         window;
   logic [63:0]          old_word0;
   logic [63:0]          old_word1;
   logic                 out_free;

   // Only one request is in flight; anything beyond idle holds the input off.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign word0 = AW'(base_ff >> 6);
   assign word1 = word0 + 1'b1;

   assign read_in_range = ({2'b00, req_payload.read_addr} < 12'(FRAME_BYTES));
   assign read_word     = AW'(req_payload.read_addr >> 3);

   // The group's 64-pixel window starts at the pixel offset inside word0 and may
   // run into the next word; the upper half lands in word0, the lower in word1.
   assign window = {(spread_bits(src_ff) << pass_ff), 64'b0} >> base_ff[5:0];

   // Words never written since reset or start read as zero.
   assign old_word0 = valid_ff[word0] ? ram_rd_data : 64'b0;
   assign old_word1 = valid_ff[word1] ? ram_rd_data : 64'b0;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign seq_clear = req_accept && (req_payload.action == ACT_START);
   assign seq_push  = req_accept && (req_payload.action == ACT_PUSH);

   fbir_seq #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .clear (seq_clear),
      .push  (seq_push),
      .info  (seq_info)
   );

   fbir_ram #(
      .DATA_W (64),
      .DEPTH  (FRAME_WORDS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Frame RAM port control follows the state directly.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = word0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = word0;
      ram_wr_data = old_word0 | hi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_en   = req_accept && (req_payload.action == ACT_READ) && read_in_range;
            ram_rd_addr = read_word;
         end
         ST_MASK: begin
            ram_rd_en = 1'b1;
         end
         ST_WR0: begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = (lo_ff != 64'b0);
            ram_rd_addr = word1;
         end
         ST_WR1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = word1;
            ram_wr_data = old_word1 | lo_ff;
         end
         default: begin
         end
      endcase
   end

   // Next-state and register update logic.
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      row_in       = row_ff;
      group_in     = group_ff;
      pass_in      = pass_ff;
      src_in       = src_ff;
      base_in      = base_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      sel_in       = sel_ff;
      rd_ok_in     = rd_ok_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_payload.action)
                  ACT_START: begin
                     valid_in = '0;
                  end
                  ACT_PUSH: begin
                     // The counter itself ignores pushes past the frame.
                     if (seq_info.in_frame && seq_info.row_ok) begin
                        row_in   = seq_info.row;
                        group_in = seq_info.group;
                        pass_in  = seq_info.pass;
                        src_in   = req_payload.src_byte;
                        state_in = ST_BASE;
                     end
                  end
                  ACT_READ: begin
                     sel_in   = req_payload.read_addr[2:0];
                     rd_ok_in = read_in_range && valid_ff[read_word];
                     cmp_in   = seq_info.complete;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BASE: begin
            base_in  = PW'(row_ff * WIDTH) + PW'({group_ff, 6'b0});
            state_in = ST_MASK;
         end
         ST_MASK: begin
            hi_in    = window[127:64];
            lo_in    = window[63:0];
            state_in = ST_WR0;
         end
         ST_WR0: begin
            valid_in[word0] = 1'b1;
            state_in        = (lo_ff != 64'b0) ? ST_WR1 : ST_IDLE;
         end
         ST_WR1: begin
            valid_in[word1] = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_READ: begin
            if (out_free) begin
               rsp_in.dst_byte       = rd_ok_ff ?
                                       8'(ram_rd_data >> {~sel_ff, 3'b000}) : 8'h00;
               rsp_in.frame_complete = cmp_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff   <= row_in;
      group_ff <= group_in;
      pass_ff  <= pass_in;
      src_ff   <= src_in;
      base_ff  <= base_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      sel_ff   <= sel_in;
      rd_ok_ff <= rd_ok_in;
      cmp_ff   <= cmp_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // A start request leaves every frame word marked unwritten.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.action == ACT_START)) |=> (valid_ff == '0))
      else $error("frame valid bits not cleared after start");

   // The second write of a push happens only when the group straddles a word.
   a_wr1_needs_spill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR1) |-> (lo_ff != 64'b0))
      else $error("second word written without pixels spilling into it");

   // A new result only ever comes out of the read-wait state.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_READ))
      else $error("result raised outside of a read");
`endif

endmodule

`default_nettype wire

### rtl/fbir_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module fbir_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fbir_seq.sv
// Push sequence counter: tracks the push count, the group index and the
// row/pass/band counter, and reports where the next source byte lands.
// Depends on fbir_pkg.
`default_nettype none

module fbir_seq #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  push,
   output fbir_pkg::seq_info_type     info
);
   import fbir_pkg::*;

   localparam int FRAME_BYTES = (WIDTH * HEIGHT) / 8;
   localparam int GROUPS      = (WIDTH / GROUP_PIXELS > 0) ? WIDTH / GROUP_PIXELS : 1;
   localparam int CW          = $clog2(FRAME_BYTES + 1);
   localparam int JW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   logic [CW-1:0]   count_ff, count_in;
   logic [JW-1:0]   group_ff, group_in;
   logic [CW-1:0]   step_ff,  step_in;
   logic [CW-4:0]   row_full;
   logic            in_frame;

   assign in_frame = (count_ff < CW'(FRAME_BYTES));

   // Row is band * 8 + r, where r is the low three bits and band starts at bit 6.
   assign row_full = {step_ff[CW-1:6], step_ff[2:0]};

   always_comb begin
      count_in = count_ff;
      group_in = group_ff;
      step_in  = step_ff;
      if (clear) begin
         count_in = '0;
         group_in = '0;
         step_in  = '0;
      end else if (push && in_frame) begin
         count_in = count_ff + 1'b1;
         if (group_ff == JW'(GROUPS - 1)) begin
            group_in = '0;
            step_in  = step_ff + 1'b1;
         end else begin
            group_in = group_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         group_ff <= '0;
         step_ff  <= '0;
      end else begin
         count_ff <= count_in;
         group_ff <= group_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      info          = '0;
      info.in_frame = in_frame;
      info.row_ok   = (row_full < (CW-3)'(HEIGHT));
      info.complete = !in_frame;
      info.row      = ROW_W'(row_full);
      info.group    = GROUP_W'(group_ff);
      info.pass     = step_ff[5:3];
   end

endmodule

`default_nettype wire
